// ----- sv/brfifo_pkg.sv -----
// ----------------------------------------------------------------------------
// brfifo_pkg
// Shared widths, action codes and the command record for the byte ring fifo.
// ----------------------------------------------------------------------------
package brfifo_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BURST_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int FILL_W   = 11;

    // stream packing
    localparam int S_TDATA_W = 16;  // data_in, request_length, pad
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 24;  // data_out, fill_level, pad
    localparam int M_TUSER_W = 2;   // byte_valid, accepted

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_PEEK,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;   // already clamped to the burst limit
    } t_cmd;

endpackage

// ----- sv/byte_ring_fifo_with_peek.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek
// Circular byte fifo with write, read-and-remove and peek requests.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue at up to one per cycle while the queue has
// room; the execution side takes one request at a time. A write gives one result
// with accepted set unless the ring is full. A read or peek of n bytes
// (n = min(length, MAX_BURST, fill)) takes a setup step in the idle state and then
// one byte per cycle while the output register is free, paced by the single read
// port of the byte ram and the output register; an empty ring, a zero length
// or an unused action gives one empty result. Results wait in the output register
// while new requests keep filling the queue.
module byte_ring_fifo_with_peek #(
    parameter int DEPTH     = brfifo_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brfifo_pkg::MAX_BURST_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [brfifo_pkg::S_TDATA_W-1:0] i_s_axis_tdata,   // data_in, request_length
    input  logic [brfifo_pkg::S_TUSER_W-1:0] i_s_axis_tuser,   // action
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [brfifo_pkg::M_TDATA_W-1:0] o_m_axis_tdata,   // data_out, fill_level
    output logic [brfifo_pkg::M_TUSER_W-1:0] o_m_axis_tuser,   // byte_valid, accepted
    output logic                             o_m_axis_tlast
);
    import brfifo_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    brfifo_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    brfifo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- sv/brfifo_ram.sv -----
// ----------------------------------------------------------------------------
// brfifo_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module brfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/brfifo_front.sv -----
// ----------------------------------------------------------------------------
// brfifo_front
// Accepts requests, decodes the action, clamps the length and queues them.
// ----------------------------------------------------------------------------
module brfifo_front #(
    parameter int MAX_BURST = brfifo_pkg::MAX_BURST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [brfifo_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [brfifo_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                            o_cmd_valid,
    output brfifo_pkg::t_cmd                o_cmd,
    input  logic                            i_cmd_pop
);
    import brfifo_pkg::*;

    t_cmd              r_q [2];
    logic              r_wr_idx;
    logic              r_rd_idx;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              push;
    t_cmd              dec;
    logic [LEN_W-1:0]  len_in;

    assign len_in = i_s_axis_tdata[DATA_W +: LEN_W];

    always_comb begin
        unique case (i_s_axis_tuser)
            ACT_WRITE: dec.kind = KIND_WRITE;
            ACT_READ:  dec.kind = KIND_READ;
            ACT_PEEK:  dec.kind = KIND_PEEK;
            default:   dec.kind = KIND_NONE;
        endcase
        dec.data = i_s_axis_tdata[DATA_W-1:0];
        dec.len  = (len_in > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : len_in;
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_cnt != 2'd0);
    assign o_cmd           = r_q[r_rd_idx];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= dec;
        end
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (i_cmd_pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/brfifo_back.sv -----
// ----------------------------------------------------------------------------
// brfifo_back
// Executes queued requests against the byte ring and drives the result stream.
// ----------------------------------------------------------------------------
module brfifo_back #(
    parameter int DEPTH = brfifo_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  brfifo_pkg::t_cmd                 i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [brfifo_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // data_out, fill_level
    output logic [brfifo_pkg::M_TUSER_W-1:0] o_m_axis_tuser,  // byte_valid, accepted
    output logic                             o_m_axis_tlast
);
    import brfifo_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_p, n_p;
    logic [CW-1:0]     r_count, n_count;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_remove, n_remove;
    logic              r_out_valid, n_out_valid;
    logic              r_byte_valid, n_byte_valid;
    logic              r_accepted, n_accepted;
    logic              r_last, n_last;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic              slot_free;
    logic              full;
    logic [LEN_W-1:0]  burst_len;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_q;

    function automatic logic [PW-1:0] wrap_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    brfifo_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (r_p),
        .o_rdata (ram_q)
    );

    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign full      = (r_count == CW'(DEPTH));
    assign burst_len = (MW'(r_count) < MW'(i_cmd.len)) ? LEN_W'(r_count) : i_cmd.len;

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_p          = r_p;
        n_count      = r_count;
        n_left       = r_left;
        n_remove     = r_remove;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_byte_valid = r_byte_valid;
        n_accepted   = r_accepted;
        n_last       = r_last;
        n_fill       = r_fill;
        o_cmd_pop    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_pop    = 1'b1;
                    n_out_valid  = 1'b1;
                    n_byte_valid = 1'b0;
                    n_accepted   = 1'b0;
                    n_last       = 1'b1;
                    n_fill       = FILL_W'(r_count);
                    case (i_cmd.kind) inside
                        KIND_WRITE: begin
                            if (!full) begin
                                ram_we     = 1'b1;
                                n_wp       = wrap_ptr(r_wp);
                                n_count    = r_count + 1'b1;
                                n_accepted = 1'b1;
                                n_fill     = FILL_W'(r_count + 1'b1);
                            end
                        end
                        KIND_READ, KIND_PEEK: begin
                            // empty ring or zero length keeps the single empty result
                            if (burst_len != '0) begin
                                n_out_valid = 1'b0;
                                n_state     = ST_BURST;
                                n_left      = burst_len;
                                n_p         = r_rp;
                                n_remove    = (i_cmd.kind == KIND_READ);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BURST: begin
                if (slot_free) begin
                    // ram data lands on the same edge as the result flags
                    ram_re       = 1'b1;
                    n_p          = wrap_ptr(r_p);
                    n_out_valid  = 1'b1;
                    n_byte_valid = 1'b1;
                    n_accepted   = 1'b0;
                    n_last       = (r_left == LEN_W'(1));
                    n_left       = r_left - 1'b1;
                    if (r_remove) begin
                        n_count = r_count - 1'b1;
                        n_rp    = wrap_ptr(r_p);
                        n_fill  = FILL_W'(r_count - 1'b1);
                    end else begin
                        n_fill  = FILL_W'(r_count);
                    end
                    if (r_left == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_left       <= n_left;
        r_remove     <= n_remove;
        r_byte_valid <= n_byte_valid;
        r_accepted   <= n_accepted;
        r_last       <= n_last;
        r_fill       <= n_fill;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tuser  = {r_accepted, r_byte_valid};
    assign o_m_axis_tdata  = {(M_TDATA_W - DATA_W - FILL_W)'(0), r_fill,
                              (r_byte_valid ? ram_q : DATA_W'(0))};

endmodule

// ----- sv/brfifo_checker.sv -----
// ----------------------------------------------------------------------------
// brfifo_checker
// Port-level checks on the byte ring fifo result stream.
// ----------------------------------------------------------------------------
module brfifo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // results without a byte always end their request
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("byte-less result not marked last");

    // a byte result is never also a write acknowledge
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("byte_valid and accepted both set");

    // data is zero unless a byte is returned
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("data_out not zero on byte-less result");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind byte_ring_fifo_with_peek brfifo_checker u_brfifo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring fifo: random write, read and peek
// requests against an in-bench ring predictor, with random stalls on both
// streams, a long receiver hold-off and a fill phase.
// ----------------------------------------------------------------------------
module tb;
    import brfifo_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int BURST_MAX  = MAX_BURST_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 80;
    localparam int LONG_HOLD    = 400;
    localparam int FILL_WRITES  = 40;
    localparam int RANDOM_ITEMS = 246;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   data;
        logic [LEN_W-1:0]    len;
        bit                  drain;   // sender waits for all results first
    } t_request;

    typedef struct {
        logic [DATA_W-1:0] data;
        bit                byte_valid;
        bit                accepted;
        bit                last;
        logic [FILL_W-1:0] fill;
    } t_outcome;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_valid;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_ready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    byte_ring_fifo_with_peek u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),   // data_in, request_length
        .i_s_axis_tuser  (s_tuser),   // action
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),   // data_out, fill_level
        .o_m_axis_tuser  (m_tuser),   // byte_valid, accepted
        .o_m_axis_tlast  (m_tlast)
    );

    // predictor state
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int                ring_wr;
    int                ring_rd;
    int                ring_fill;

    t_request pending_req_q[$];
    t_outcome due_result_q[$];
    t_request cur_req;

    int  err_cnt;
    int  sent_cnt;
    int  got_cnt;
    int  gap_cnt;
    int  hold_cnt;
    bit  long_hold_done;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d want %0d", got_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic push_outcome(input logic [DATA_W-1:0] data, input bit vld, input bit acc,
                                input bit last);
        t_outcome o;
        o.data       = data;
        o.byte_valid = vld;
        o.accepted   = acc;
        o.last       = last;
        o.fill       = ring_fill[FILL_W-1:0];
        due_result_q.push_back(o);
    endtask

    task automatic ring_predict(input t_request rq);
        int n;
        int p;
        case (rq.action)
            ACT_WRITE: begin
                if (ring_fill >= RING_DEPTH) begin
                    push_outcome('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    ring_mem[ring_wr] = rq.data;
                    ring_wr = (ring_wr + 1) % RING_DEPTH;
                    ring_fill++;
                    push_outcome('0, 1'b0, 1'b1, 1'b1);
                end
            end
            ACT_READ, ACT_PEEK: begin
                n = rq.len;
                if (n > BURST_MAX) n = BURST_MAX;
                if (n > ring_fill) n = ring_fill;
                if (n == 0) begin
                    push_outcome('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    p = ring_rd;
                    for (int k = 0; k < n; k++) begin
                        logic [DATA_W-1:0] b;
                        b = ring_mem[p];
                        p = (p + 1) % RING_DEPTH;
                        if (rq.action == ACT_READ) begin
                            ring_fill--;
                            ring_rd = p;
                        end
                        push_outcome(b, 1'b1, 1'b0, k == n - 1);
                    end
                end
            end
            default: push_outcome('0, 1'b0, 1'b0, 1'b1);
        endcase
    endtask

    task automatic add_req(input logic [ACTION_W-1:0] action, input int data, input int len,
                           input bit drain);
        t_request rq;
        rq.action = action;
        rq.data   = data[DATA_W-1:0];
        rq.len    = len[LEN_W-1:0];
        rq.drain  = drain;
        pending_req_q.push_back(rq);
    endtask

    function automatic int pick_gap();
        int r;
        if ((sent_cnt / 48) % 3 == 1) return 0;   // stretch with no idling
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drv
        int g;
        g = gap_cnt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            gap_cnt = 0;
        end else begin
            if (s_valid && s_ready) begin
                ring_predict(cur_req);
                sent_cnt++;
                g = pick_gap();
            end
            if (s_valid && !s_ready) begin
                // hold the request until it is taken
            end else if (g > 0) begin
                s_valid <= 1'b0;
                g--;
            end else if (pending_req_q.size() > 0 &&
                         !(pending_req_q[0].drain && due_result_q.size() > 0)) begin
                cur_req = pending_req_q.pop_front();
                s_valid <= 1'b1;
                s_tdata <= {{(S_TDATA_W - LEN_W - DATA_W){1'b0}}, cur_req.len, cur_req.data};
                s_tuser <= cur_req.action;
            end else begin
                s_valid <= 1'b0;
            end
            gap_cnt = g;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : mon
        t_outcome w;
        int r;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_result_q.size() == 0) begin
                    report_mismatch("unexpected result, data", m_tdata[DATA_W-1:0], 0);
                end else begin
                    w = due_result_q.pop_front();
                    if (m_tdata[DATA_W-1:0] !== w.data)
                        report_mismatch("data_out", m_tdata[DATA_W-1:0], w.data);
                    if (m_tuser[0] !== w.byte_valid)
                        report_mismatch("byte_valid", m_tuser[0], w.byte_valid);
                    if (m_tuser[1] !== w.accepted)
                        report_mismatch("accepted", m_tuser[1], w.accepted);
                    if (m_tlast !== w.last)
                        report_mismatch("last", m_tlast, w.last);
                    if (m_tdata[DATA_W +: FILL_W] !== w.fill)
                        report_mismatch("fill_level", m_tdata[DATA_W +: FILL_W], w.fill);
                end
                got_cnt++;
            end
            // one long hold-off so the request side backs up and stalls
            if (!long_hold_done && got_cnt >= 150) begin
                hold_cnt = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_cnt == 0 && (got_cnt / 60) % 3 != 2) begin
                r = $urandom_range(0, 99);
                if (r >= 95)      hold_cnt = $urandom_range(15, 50);
                else if (r >= 75) hold_cnt = $urandom_range(1, 3);
            end
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
                hold_cnt--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("** byte_ring_fifo_with_peek: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int items;
        int run;
        int r;
        int len;
        err_cnt        = 0;
        sent_cnt       = 0;
        got_cnt        = 0;
        long_hold_done = 1'b0;
        ring_wr        = 0;
        ring_rd        = 0;
        ring_fill      = 0;
        idle_cycles    = 0;
        s_valid        = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_ready        = 1'b0;
        i_rst_n        = 1'b0;

        // empty ring, zero length and the unused code, then writes, peeks and reads on a small fill
        add_req(ACT_READ, 8'h3c, 5, 1'b0);
        add_req(ACT_PEEK, 8'hc3, 0, 1'b0);
        add_req(ACT_UNUSED, 8'hff, 127, 1'b0);
        add_req(ACT_WRITE, 8'h00, 0, 1'b0);
        add_req(ACT_WRITE, 8'hff, 127, 1'b0);
        add_req(ACT_WRITE, 8'ha5, 64, 1'b0);
        add_req(ACT_WRITE, 8'h5a, 1, 1'b0);
        add_req(ACT_PEEK, 8'h00, 0, 1'b0);
        add_req(ACT_PEEK, 8'h00, 2, 1'b0);
        add_req(ACT_PEEK, 8'h00, 127, 1'b0);
        add_req(ACT_READ, 8'h00, 1, 1'b0);
        add_req(ACT_UNUSED, 8'h00, 0, 1'b0);
        add_req(ACT_READ, 8'h00, 127, 1'b0);

        // fill with writes, then bursts clamped by the fill
        for (int i = 0; i < FILL_WRITES; i++)
            add_req(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 127), 1'b0);
        add_req(ACT_WRITE, 8'h77, 0, 1'b1);
        add_req(ACT_WRITE, 8'h88, 0, 1'b0);
        add_req(ACT_READ, 8'h00, 0, 1'b0);
        add_req(ACT_PEEK, 8'h00, 127, 1'b0);
        add_req(ACT_PEEK, 8'h00, 64, 1'b0);
        add_req(ACT_READ, 8'h00, 65, 1'b0);
        add_req(ACT_WRITE, 8'h99, 0, 1'b0);
        add_req(ACT_READ, 8'h00, 64, 1'b0);
        add_req(ACT_PEEK, 8'h00, 1, 1'b0);
        for (int i = 0; i < 12; i++)
            add_req(ACT_READ, 8'h00, 100, 1'b0);

        // random: runs of writes broken up by reads, peeks and noise
        items = 0;
        while (items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                run = $urandom_range(1, 14);
                for (int i = 0; i < run; i++)
                    add_req(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 127),
                            items == 0 || items % 150 == 0);
                items += run;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = $urandom_range(0, 12);
                else if (r < 90) len = $urandom_range(13, 70);
                else             len = $urandom_range(71, 127);
                r = $urandom_range(0, 99);
                if (r < 50)
                    add_req(ACT_READ, $urandom_range(0, 255), len, 1'b0);
                else if (r < 90)
                    add_req(ACT_PEEK, $urandom_range(0, 255), len, 1'b0);
                else
                    add_req(ACT_UNUSED, $urandom_range(0, 255), len, 1'b0);
                items++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_req_q.size() == 0 && !s_valid);
        wait (due_result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && due_result_q.size() == 0) begin
            $display("** byte_ring_fifo_with_peek: PASSED **");
        end else begin
            $display("** byte_ring_fifo_with_peek: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/brfifo_pkg.sv
sv/brfifo_ram.sv
sv/brfifo_front.sv
sv/brfifo_back.sv
sv/byte_ring_fifo_with_peek.sv
sv/brfifo_checker.sv
test/tb.sv
